FILE: sv/trs_euler_transform_composer_top_defines.svh
// Assertion macros for the transform composer
`ifndef TRS_EULER_TRANSFORM_COMPOSER_TOP_DEFINES_SVH
`define TRS_EULER_TRANSFORM_COMPOSER_TOP_DEFINES_SVH
// property a implies b on the same edge
`define TRS_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("trs check failed");
// property a implies b on the following edge
`define TRS_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("trs check failed");
`endif

FILE: sv/trs_pkg.sv
// Constants and types for the transform composer
`timescale 1ns / 1ps
package trs_pkg;
    localparam int Steps = 24;
    localparam logic signed [33:0] GainQ30 = 34'sd652032874;
    localparam logic [28:0] HalfPiQ28 = 29'd421657428;
    localparam logic signed [31:0] OneQ30 = 32'sd1073741824;
    typedef logic signed [33:0] t_q30;

    function automatic logic signed [31:0] atan_q28(input logic [4:0] i);
        logic signed [31:0] v;
        case (i)
            5'd0: v = 32'sd210828714;
            5'd1: v = 32'sd124459457;
            5'd2: v = 32'sd65760959;
            5'd3: v = 32'sd33381290;
            5'd4: v = 32'sd16755422;
            5'd5: v = 32'sd8385879;
            5'd6: v = 32'sd4193963;
            5'd7: v = 32'sd2097109;
            5'd8: v = 32'sd1048571;
            5'd9: v = 32'sd524287;
            default: v = 32'sd1 <<< (5'd28 - i);
        endcase
        return v;
    endfunction

    // rounded Q30 product
    function automatic t_q30 mul_q30(input t_q30 a, input t_q30 b);
        logic signed [67:0] p;
        p = 68'(a) * 68'(b) + 68'sd536870912;
        return t_q30'(p >>> 30);
    endfunction
endpackage

FILE: sv/trs_euler_transform_composer_top.sv
// Top level: TRS model matrix composer
`timescale 1ns / 1ps
// Input channel: one request carries three angles (1/65536 turn), three
// Q16.16 translations and three Q16.16 scale factors. It is taken when
// i_in_valid is high and o_in_stall low.
// Output channel: four results per request, rows 0..3 of the matrix
// M = T*Rz*Ry*Rx*S, each with four Q16.16 saturated elements, the row index
// and a last-row flag. Taken when o_out_valid is high and i_out_stall low.
// Pipeline: 25 CORDIC stages and three product stages (A, B, C), then the row
// serializer, which sends one row per cycle while i_out_stall is low.
// Throughput: the single result channel sends four rows per request. The whole
// pipeline advances only when the row serializer can take a new matrix (idle
// or on its last row); a stall freezes every stage.
// Reset (synchronous, active low) clears all valid bits and the row counter.
module trs_euler_transform_composer_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [15:0]        i_angle_x,
    input  logic [15:0]        i_angle_y,
    input  logic [15:0]        i_angle_z,
    input  logic signed [31:0] i_shift_x,
    input  logic signed [31:0] i_shift_y,
    input  logic signed [31:0] i_shift_z,
    input  logic signed [31:0] i_factor_x,
    input  logic signed [31:0] i_factor_y,
    input  logic signed [31:0] i_factor_z,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_elem_col0,
    output logic signed [31:0] o_elem_col1,
    output logic signed [31:0] o_elem_col2,
    output logic signed [31:0] o_elem_col3,
    output logic [1:0]         o_row_index,
    output logic               o_last_row
);
    import trs_pkg::*;
`include "trs_euler_transform_composer_top_defines.svh"

    localparam int Lat = Steps + 1;   // CORDIC register stages
    localparam int Depth = Lat + 3;   // plus three product stages

    logic w_adv;
    logic [Depth-1:0] r_vld;
    logic signed [31:0] r_t [Lat][3];
    logic signed [31:0] r_f [Lat][3];
    t_q30 w_cx, w_sx, w_cy, w_sy, w_cz, w_sz;

    // matrix row serializer
    logic r_busy;
    logic [1:0] r_row;
    logic signed [31:0] r_m [3][4];

    function automatic logic signed [67:0] mul_q30w(input t_q30 a,
                                                    input logic signed [31:0] b);
        logic signed [67:0] p;
        p = 68'(a) * 68'(b) + 68'sd536870912;
        return p >>> 30;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] o;
        if (v > 68'sd2147483647) o = 32'h7fffffff;
        else if (v < -68'sd2147483648) o = 32'h80000000;
        else o = v[31:0];
        return o;
    endfunction

    assign w_adv = !r_busy || (r_row == 2'd3 && !i_out_stall);
    assign o_in_stall = !w_adv;

    trs_cordic u_cx (.i_clk, .i_en(w_adv), .i_ang(i_angle_x), .o_cos(w_cx), .o_sin(w_sx));
    trs_cordic u_cy (.i_clk, .i_en(w_adv), .i_ang(i_angle_y), .o_cos(w_cy), .o_sin(w_sy));
    trs_cordic u_cz (.i_clk, .i_en(w_adv), .i_ang(i_angle_z), .o_cos(w_cz), .o_sin(w_sz));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[Depth-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_t[0] <= '{i_shift_x, i_shift_y, i_shift_z};
            r_f[0] <= '{i_factor_x, i_factor_y, i_factor_z};
            for (int i = 1; i < Lat; i++) begin
                r_t[i] <= r_t[i-1];
                r_f[i] <= r_f[i-1];
            end
        end
    end

    // stage A: first products
    t_q30 r_a_czsy, r_a_szsy, r_a_r00, r_a_r10, r_a_r21, r_a_r22, r_a_szsx;
    t_q30 r_a_szcx, r_a_czcx, r_a_czsx, r_a_ncy, r_a_sx, r_a_cx;
    logic signed [31:0] r_a_t [3];
    logic signed [31:0] r_a_f [3];
    // stage B: 3x3 rotation
    t_q30 r_b_r [3][3];
    logic signed [31:0] r_b_t [3];
    logic signed [31:0] r_b_f [3];
    // stage C: scaled, saturated
    logic signed [31:0] r_c_m [3][3];
    logic signed [31:0] r_c_t [3];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_czsy <= mul_q30(w_cz, w_sy);
            r_a_szsy <= mul_q30(w_sz, w_sy);
            r_a_r00 <= mul_q30(w_cz, w_cy);
            r_a_r10 <= mul_q30(w_sz, w_cy);
            r_a_r21 <= mul_q30(w_cy, w_sx);
            r_a_r22 <= mul_q30(w_cy, w_cx);
            r_a_szsx <= mul_q30(w_sz, w_sx);
            r_a_szcx <= mul_q30(w_sz, w_cx);
            r_a_czcx <= mul_q30(w_cz, w_cx);
            r_a_czsx <= mul_q30(w_cz, w_sx);
            r_a_ncy <= -w_sy;
            r_a_sx <= w_sx;
            r_a_cx <= w_cx;
            r_a_t <= r_t[Lat-1];
            r_a_f <= r_f[Lat-1];

            r_b_r[0][0] <= r_a_r00;
            r_b_r[0][1] <= mul_q30(r_a_czsy, r_a_sx) - r_a_szcx;
            r_b_r[0][2] <= r_a_szsx + mul_q30(r_a_czsy, r_a_cx);
            r_b_r[1][0] <= r_a_r10;
            r_b_r[1][1] <= r_a_czcx + mul_q30(r_a_szsy, r_a_sx);
            r_b_r[1][2] <= mul_q30(r_a_szsy, r_a_cx) - r_a_czsx;
            r_b_r[2][0] <= r_a_ncy;
            r_b_r[2][1] <= r_a_r21;
            r_b_r[2][2] <= r_a_r22;
            r_b_t <= r_a_t;
            r_b_f <= r_a_f;

            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_c_m[r][c] <= sat32(mul_q30w(r_b_r[r][c], r_b_f[c]));
                end
            end
            r_c_t <= r_b_t;
        end
    end

    // r_vld[Depth-1] marks a matrix ready in stage C
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row <= '0;
        end else if (w_adv) begin
            r_busy <= r_vld[Depth-1];
            r_row <= '0;
        end else if (!i_out_stall) begin
            r_row <= r_row + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int r = 0; r < 3; r++) begin
                r_m[r] <= '{r_c_m[r][0], r_c_m[r][1], r_c_m[r][2], r_c_t[r]};
            end
        end
    end

    assign o_out_valid = r_busy;
    assign o_row_index = r_row;
    assign o_last_row = (r_row == 2'd3);
    always_comb begin
        if (r_row == 2'd3) begin
            o_elem_col0 = '0;
            o_elem_col1 = '0;
            o_elem_col2 = '0;
            o_elem_col3 = 32'sh00010000;
        end else begin
            o_elem_col0 = r_m[r_row][0];
            o_elem_col1 = r_m[r_row][1];
            o_elem_col2 = r_m[r_row][2];
            o_elem_col3 = r_m[r_row][3];
        end
    end

    `TRS_ASSERT_IMP(a_idle_row0, i_clk, i_rst_n, !r_busy, r_row == 2'd0)
    `TRS_ASSERT_NEXT(a_row_step, i_clk, i_rst_n, r_busy && i_out_stall, $stable(r_row) && r_busy)
    `TRS_ASSERT_IMP(a_stall_adv, i_clk, i_rst_n, r_busy && r_row != 2'd3, o_in_stall)
endmodule

FILE: sv/trs_cordic.sv
// Pipelined CORDIC sine/cosine, one step per stage
`timescale 1ns / 1ps
module trs_cordic (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [15:0]         i_ang,
    output trs_pkg::t_q30       o_cos,
    output trs_pkg::t_q30       o_sin
);
    import trs_pkg::*;
    // stage 0 holds the Q28 angle; stages 1..Steps hold the iterations
    t_q30 r_x [Steps+1];
    t_q30 r_y [Steps+1];
    logic signed [31:0] r_z [Steps+1];
    logic [1:0] r_quad [Steps+1];
    logic r_zero [Steps+1];
    logic [43:0] n_zp;
    t_q30 w_c, w_s;

    assign n_zp = 44'(i_ang[13:0]) * 44'(HalfPiQ28) + 44'd8192;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= GainQ30;
            r_y[0] <= '0;
            r_z[0] <= 32'(n_zp >> 14);
            r_quad[0] <= i_ang[15:14];
            r_zero[0] <= (i_ang[13:0] == '0);
            for (int i = 0; i < Steps; i++) begin
                if (!r_z[i][31]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - atan_q28(5'(i));
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + atan_q28(5'(i));
                end
                r_quad[i+1] <= r_quad[i];
                r_zero[i+1] <= r_zero[i];
            end
        end
    end

    assign w_c = r_zero[Steps] ? t_q30'(OneQ30) : r_x[Steps];
    assign w_s = r_zero[Steps] ? '0 : r_y[Steps];

    always_comb begin
        case (r_quad[Steps])
            2'd0: begin o_cos = w_c;  o_sin = w_s;  end
            2'd1: begin o_cos = -w_s; o_sin = w_c;  end
            2'd2: begin o_cos = -w_c; o_sin = -w_s; end
            default: begin o_cos = w_s; o_sin = -w_c; end
        endcase
    end
endmodule

FILE: tb/sv/trs_matrix_checker.sv
// Checker for the transform composer: predicts matrix rows and compares them
`timescale 1ns / 1ps
module trs_matrix_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [15:0]        i_angle_x,
    input  logic [15:0]        i_angle_y,
    input  logic [15:0]        i_angle_z,
    input  logic signed [31:0] i_shift_x,
    input  logic signed [31:0] i_shift_y,
    input  logic signed [31:0] i_shift_z,
    input  logic signed [31:0] i_factor_x,
    input  logic signed [31:0] i_factor_y,
    input  logic signed [31:0] i_factor_z,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [31:0] i_elem_col0,
    input  logic signed [31:0] i_elem_col1,
    input  logic signed [31:0] i_elem_col2,
    input  logic signed [31:0] i_elem_col3,
    input  logic [1:0]         i_row_index,
    input  logic               i_last_row,
    output int                 o_fail_count,
    output int                 o_rows_pending
);
    typedef struct packed {
        logic signed [31:0] c0;
        logic signed [31:0] c1;
        logic signed [31:0] c2;
        logic signed [31:0] c3;
        logic [1:0]         row;
        logic               last;
    } t_row;

    localparam int CordicSteps = 24;
    localparam longint GainQ30 = 64'sd652032874;
    localparam longint HalfPiQ28 = 64'sd421657428;
    localparam longint OneQ30 = 64'sd1073741824;

    longint arctan_q28 [CordicSteps] = '{
        210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
        4193963, 2097109, 1048571, 524287, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048,
        1024, 512, 256, 128, 64, 32
    };

    t_row expected_rows[$];
    int   fail_count;

    assign o_fail_count = fail_count;
    assign o_rows_pending = expected_rows.size();

    // >>> on a signed longint is a floor shift
    function automatic longint rnd_q30(longint a, longint b);
        return (a * b + 64'sd536870912) >>> 30;
    endfunction

    function automatic void sine_cosine(logic [15:0] ang, output longint c_o,
                                        output longint s_o);
        longint x, y, z, dx, dy, c, s;
        longint frac;
        frac = ang[13:0];
        if (frac == 0) begin
            c = OneQ30;
            s = 0;
        end else begin
            x = GainQ30;
            y = 0;
            z = (frac * HalfPiQ28 + 8192) >>> 14;
            for (int i = 0; i < CordicSteps; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= arctan_q28[i];
                end else begin
                    x += dx; y -= dy; z += arctan_q28[i];
                end
            end
            c = x;
            s = y;
        end
        case (ang[15:14])
            2'd0: begin c_o = c;  s_o = s;  end
            2'd1: begin c_o = -s; s_o = c;  end
            2'd2: begin c_o = -c; s_o = -s; end
            default: begin c_o = s; s_o = -c; end
        endcase
    endfunction

    function automatic logic signed [31:0] scale_sat(longint e, longint f);
        longint v;
        v = rnd_q30(e, f);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    task automatic predict_matrix();
        longint cx, sx, cy, sy, cz, sz, czsy, szsy;
        longint r [3][3];
        longint fac [3];
        longint sh [3];
        t_row rw;
        sine_cosine(i_angle_x, cx, sx);
        sine_cosine(i_angle_y, cy, sy);
        sine_cosine(i_angle_z, cz, sz);
        fac[0] = i_factor_x; fac[1] = i_factor_y; fac[2] = i_factor_z;
        sh[0] = i_shift_x; sh[1] = i_shift_y; sh[2] = i_shift_z;
        czsy = rnd_q30(cz, sy);
        szsy = rnd_q30(sz, sy);
        r[0][0] = rnd_q30(cz, cy);
        r[0][1] = rnd_q30(czsy, sx) - rnd_q30(sz, cx);
        r[0][2] = rnd_q30(sz, sx) + rnd_q30(czsy, cx);
        r[1][0] = rnd_q30(sz, cy);
        r[1][1] = rnd_q30(cz, cx) + rnd_q30(szsy, sx);
        r[1][2] = rnd_q30(szsy, cx) - rnd_q30(cz, sx);
        r[2][0] = -sy;
        r[2][1] = rnd_q30(cy, sx);
        r[2][2] = rnd_q30(cy, cx);
        for (int k = 0; k < 3; k++) begin
            rw.c0 = scale_sat(r[k][0], fac[0]);
            rw.c1 = scale_sat(r[k][1], fac[1]);
            rw.c2 = scale_sat(r[k][2], fac[2]);
            rw.c3 = sh[k][31:0];
            rw.row = 2'(k);
            rw.last = 1'b0;
            expected_rows.push_back(rw);
        end
        rw = '{c0: 0, c1: 0, c2: 0, c3: 32'sh00010000, row: 2'd3, last: 1'b1};
        expected_rows.push_back(rw);
    endtask

    task automatic compare_row();
        t_row e;
        if (expected_rows.size() == 0) begin
            $error("row with nothing expected: row_index %0d", i_row_index);
            fail_count++;
            return;
        end
        e = expected_rows.pop_front();
        if (i_elem_col0 !== e.c0) begin
            $error("elem_col0 exp %0d got %0d", e.c0, i_elem_col0); fail_count++;
        end
        if (i_elem_col1 !== e.c1) begin
            $error("elem_col1 exp %0d got %0d", e.c1, i_elem_col1); fail_count++;
        end
        if (i_elem_col2 !== e.c2) begin
            $error("elem_col2 exp %0d got %0d", e.c2, i_elem_col2); fail_count++;
        end
        if (i_elem_col3 !== e.c3) begin
            $error("elem_col3 exp %0d got %0d", e.c3, i_elem_col3); fail_count++;
        end
        if (i_row_index !== e.row) begin
            $error("row_index exp %0d got %0d", e.row, i_row_index); fail_count++;
        end
        if (i_last_row !== e.last) begin
            $error("last_row exp %0d got %0d", e.last, i_last_row); fail_count++;
        end
    endtask

    initial fail_count = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) compare_row();
            if (i_in_valid && !i_in_stall) predict_matrix();
        end
    end
endmodule

FILE: tb/sv/trs_euler_transform_composer_top_tb.sv
// Testbench top: stimulus and verdict for the transform composer
`timescale 1ns / 1ps
module trs_euler_transform_composer_top_tb;
    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [15:0]        angle_x, angle_y, angle_z;
    logic signed [31:0] shift_x, shift_y, shift_z;
    logic signed [31:0] factor_x, factor_y, factor_z;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] elem_col0, elem_col1, elem_col2, elem_col3;
    logic [1:0]         row_index;
    logic               last_row;
    int                 fail_count;
    int                 rows_pending;

    trs_euler_transform_composer_top i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_angle_x(angle_x), .i_angle_y(angle_y), .i_angle_z(angle_z),
        .i_shift_x(shift_x), .i_shift_y(shift_y), .i_shift_z(shift_z),
        .i_factor_x(factor_x), .i_factor_y(factor_y), .i_factor_z(factor_z),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_elem_col0(elem_col0), .o_elem_col1(elem_col1),
        .o_elem_col2(elem_col2), .o_elem_col3(elem_col3),
        .o_row_index(row_index), .o_last_row(last_row)
    );

    trs_matrix_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_angle_x(angle_x), .i_angle_y(angle_y), .i_angle_z(angle_z),
        .i_shift_x(shift_x), .i_shift_y(shift_y), .i_shift_z(shift_z),
        .i_factor_x(factor_x), .i_factor_y(factor_y), .i_factor_z(factor_z),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_elem_col0(elem_col0), .i_elem_col1(elem_col1),
        .i_elem_col2(elem_col2), .i_elem_col3(elem_col3),
        .i_row_index(row_index), .i_last_row(last_row),
        .o_fail_count(fail_count), .o_rows_pending(rows_pending)
    );

    always begin
        clk = 1'b0; #1;
        clk = 1'b1; #1;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 1) == 0) return 0;
        return $urandom_range(1, 3);
    endfunction

    // random angle, biased toward quadrant edges and zero offset
    function automatic logic [15:0] pick_angle();
        case ($urandom_range(0, 5))
            0: return {2'($urandom), 14'd0};
            1: return {2'($urandom), 14'h3FFF};
            2: return {2'($urandom), 14'd1};
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [31:0] pick_q16();
        case ($urandom_range(0, 7))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return 32'($urandom_range(0, 32'h0003FFFF)) - 32'sh00020000;
            3: return 32'sh00010000;
            default: return 32'($urandom);
        endcase
    endfunction

    // hold the request until it is taken
    task automatic send_request(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                                logic signed [31:0] tx, logic signed [31:0] ty,
                                logic signed [31:0] tz, logic signed [31:0] fx,
                                logic signed [31:0] fy, logic signed [31:0] fz,
                                bit idle_after);
        in_valid <= 1'b1;
        angle_x <= ax; angle_y <= ay; angle_z <= az;
        shift_x <= tx; shift_y <= ty; shift_z <= tz;
        factor_x <= fx; factor_y <= fy; factor_z <= fz;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (idle_after) begin
            int g;
            g = gap_len();
            if (g > 0) begin
                in_valid <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
    endtask

    task automatic send_random(bit idle_after);
        send_request(pick_angle(), pick_angle(), pick_angle(),
                     pick_q16(), pick_q16(), pick_q16(),
                     pick_q16(), pick_q16(), pick_q16(), idle_after);
    endtask

    initial begin
        in_valid = 1'b0;
        out_stall = 1'b0;
        angle_x = '0; angle_y = '0; angle_z = '0;
        shift_x = '0; shift_y = '0; shift_z = '0;
        factor_x = '0; factor_y = '0; factor_z = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: identity, quadrant corners, extremes of every field
        send_request(0, 0, 0, 0, 0, 0, 32'sh10000, 32'sh10000, 32'sh10000, 1);
        send_request(16'h4000, 16'h8000, 16'hC000, 1, -1, 32'sh7FFFFFFF,
                     32'sh10000, 32'sh10000, 32'sh10000, 1);
        send_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'sh80000000,
                     32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
                     32'sh7FFFFFFF, 32'sh7FFFFFFF, 1);
        send_request(16'h2000, 16'h1000, 16'h3FFF, 0, 0, 0, 32'sh80000000,
                     32'sh80000000, 32'sh80000000, 1);
        send_request(16'h0001, 16'h4001, 16'h8001, -1, -1, -1, -1, -1, -1, 0);
        send_request(16'hC001, 16'h7FFF, 16'hBFFF, 32'sh55555555, 32'shAAAAAAAA,
                     32'sh55555555, 32'shAAAAAAAA, 32'sh55555555,
                     32'shAAAAAAAA, 0);
        send_request(16'h5555, 16'hAAAA, 16'h2AAA, 0, 0, 0, 0, 0, 0, 1);
        send_request(16'h1234, 16'hE000, 16'hA000, 32'sh00010000, 0, 0,
                     32'sh00008000, 32'shFFFF0000, 32'sh00020000, 1);

        // hold off until the pipeline is empty
        in_valid <= 1'b0;
        while (rows_pending != 0) @(posedge clk);

        for (int n = 0; n < 300; n++) begin
            // requests 100 to 149 form a back-to-back burst with no idling at all
            send_random(!(n >= 100 && n < 150));
        end
        in_valid <= 1'b0;

        while (rows_pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // receiver stalls, with stall-free stretches
    initial begin
        int g;
        @(posedge rst_n);
        forever begin
            if ($urandom_range(0, 3) == 0) begin
                out_stall <= 1'b0;
                repeat ($urandom_range(20, 60)) @(posedge clk);
            end
            g = gap_len();
            if (g > 0) begin
                out_stall <= 1'b1;
                repeat (g) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    initial begin
        #400000;
        $display("status: fail");
        $finish;
    end
endmodule

FILE: trs_euler_transform_composer_top.f
+incdir+sv
sv/trs_pkg.sv
sv/trs_cordic.sv
sv/trs_euler_transform_composer_top.sv
tb/sv/trs_matrix_checker.sv
tb/sv/trs_euler_transform_composer_top_tb.sv
